FILE: src/rvx_pkg.sv
package rvx_pkg;

  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_MULDIV = 7'h01;
  localparam logic [6:0] F7_ALT = 7'h20;

  localparam logic [1:0] ST_CONT = 2'd0;
  localparam logic [1:0] ST_HALT = 2'd1;
  localparam logic [1:0] ST_ILLEGAL = 2'd2;
  localparam logic [1:0] ST_AWAIT = 2'd3;

  localparam logic [1:0] MOP_NONE = 2'd0;
  localparam logic [1:0] MOP_LOAD = 2'd1;
  localparam logic [1:0] MOP_STORE = 2'd2;

  localparam logic CMD_EXEC = 1'b0;

  localparam logic [1:0] CFG_START_PC = 2'd0;
  localparam logic [1:0] CFG_EXIT_CALL = 2'd1;

  localparam logic [31:0] EXIT_CALL_RESET = 32'd93;
  localparam logic [4:0] REG_EXIT_ARG = 5'd17;
  localparam logic [4:0] DIV_LAST = 5'd31;

  typedef struct packed {
    logic cap_in;
    logic rd_src2;
    logic exec;
    logic mul;
    logic mul_fix;
    logic div_step;
    logic div_fin;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic is_mul;
    logic is_div;
    logic div_last;
  } stat_t;

endpackage

FILE: src/rvx_ctrl.sv
module rvx_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  rvx_pkg::stat_t stat,
  output rvx_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_RD2, S_EXEC, S_MUL, S_MULC, S_DIV, S_DIVF, S_FIN
  } state_t;

  state_t state;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd = '0;
    cmd.cap_in   = (state == S_IDLE) && in_valid;
    cmd.rd_src2  = (state == S_RD2);
    cmd.exec     = (state == S_EXEC);
    cmd.mul      = (state == S_MUL);
    cmd.mul_fix  = (state == S_MULC);
    cmd.div_step = (state == S_DIV);
    cmd.div_fin  = (state == S_DIVF);
    cmd.commit   = (state == S_FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: if (in_valid) state <= S_RD2;
        S_RD2: state <= S_EXEC;
        S_EXEC: begin
          if (stat.is_mul) state <= S_MUL;
          else if (stat.is_div) state <= S_DIV;
          else state <= S_FIN;
        end
        S_MUL: state <= S_MULC;
        S_MULC: state <= S_FIN;
        S_DIV: if (stat.div_last) state <= S_DIVF;
        S_DIVF: state <= S_FIN;
        S_FIN: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/rvx_dpath.sv
module rvx_dpath (
  input  logic        clk,
  input  logic        rst,
  input  rvx_pkg::cmd_t cmd,
  output rvx_pkg::stat_t stat,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        command,
  input  logic [6:0]  opcode,
  input  logic [2:0]  funct3,
  input  logic [6:0]  funct7,
  input  logic [4:0]  dest_reg,
  input  logic [4:0]  src1_reg,
  input  logic [4:0]  src2_reg,
  input  logic signed [31:0] immediate,
  input  logic [31:0] load_data,
  output logic [1:0]  status,
  output logic [31:0] next_pc,
  output logic        wb_valid,
  output logic [4:0]  wb_reg,
  output logic [31:0] wb_value,
  output logic [1:0]  mem_op,
  output logic [1:0]  mem_size,
  output logic [31:0] mem_addr,
  output logic [31:0] store_data
);

  logic [31:0] mem [32];
  logic [31:0] vld;
  logic [31:0] rdata;
  logic        rok;
  logic [4:0]  raddr;

  logic        cmd_q;
  logic [6:0]  opc_q;
  logic [2:0]  f3_q;
  logic [6:0]  f7_q;
  logic [4:0]  rd_q;
  logic [4:0]  src2_q;
  logic [31:0] imm_q;
  logic [31:0] ld_q;

  logic [31:0] pc;
  logic        ld_pend;
  logic [4:0]  ld_dest;
  logic [2:0]  ld_kind;
  logic [31:0] exit_num;

  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [31:0] b_cur;
  logic [63:0] prod;

  logic [31:0] dv_r;
  logic [31:0] dv_q;
  logic [31:0] dv_d;
  logic [4:0]  dv_cnt;
  logic        neg_q;
  logic        neg_r;
  logic        dv_zero;
  logic [32:0] dv_sh;
  logic        dv_ge;
  logic [31:0] q_fin;
  logic [31:0] r_fin;
  logic [31:0] mul_hi;
  logic        sgn_div;

  logic [1:0]  res_st;
  logic [31:0] res_npc;
  logic        res_wb;
  logic [4:0]  res_rd;
  logic [31:0] res_val;
  logic [1:0]  res_mop;
  logic [1:0]  res_msz;
  logic [31:0] res_addr;
  logic [31:0] res_sd;
  logic        res_ldset;
  logic        res_ldclr;

  logic [1:0]  n_st;
  logic [31:0] n_npc;
  logic        n_wr;
  logic [4:0]  n_rd;
  logic [31:0] n_val;
  logic [1:0]  n_mop;
  logic [1:0]  n_msz;
  logic [31:0] n_addr;
  logic [31:0] n_sd;
  logic        n_ldset;
  logic        n_ldclr;
  logic        ok;
  logic        take;
  logic [31:0] pc4;
  logic [31:0] sum_ai;
  logic [4:0]  shi;
  logic [4:0]  shr;
  logic        is_op;

  always_comb begin
    if (cmd.cap_in) raddr = src1_reg;
    else if (opc_q == rvx_pkg::OPC_SYSTEM) raddr = rvx_pkg::REG_EXIT_ARG;
    else raddr = src2_q;
  end

  assign b_cur = rok ? rdata : 32'd0;

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (res_wb && cmd.commit) begin
      mem[res_rd] <= res_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      rok <= 1'b0;
      pc <= '0;
      ld_pend <= 1'b0;
      ld_dest <= '0;
      ld_kind <= '0;
      exit_num <= rvx_pkg::EXIT_CALL_RESET;
    end else begin
      rok <= vld[raddr] && (raddr != 5'd0);
      if (cfg_we && cfg_index == rvx_pkg::CFG_EXIT_CALL) begin
        exit_num <= cfg_data;
      end
      if (cmd.commit) begin
        pc <= res_npc;
        if (res_wb) vld[res_rd] <= 1'b1;
        if (res_ldset) begin
          ld_pend <= 1'b1;
          ld_dest <= rd_q;
          ld_kind <= f3_q;
        end else if (res_ldclr) begin
          ld_pend <= 1'b0;
        end
      end
    end
  end

  assign is_op = (cmd_q == rvx_pkg::CMD_EXEC) && !ld_pend && (opc_q == rvx_pkg::OPC_OP)
                 && (f7_q == rvx_pkg::F7_MULDIV);
  assign stat.is_mul = is_op && !f3_q[2];
  assign stat.is_div = is_op && f3_q[2];
  assign stat.div_last = (dv_cnt == rvx_pkg::DIV_LAST);

  assign pc4 = pc + 32'd4;
  assign sum_ai = op_a + imm_q;
  assign shi = imm_q[4:0];
  assign shr = b_cur[4:0];

  always_comb begin
    n_st = rvx_pkg::ST_CONT;
    n_npc = pc4;
    n_wr = 1'b0;
    n_rd = rd_q;
    n_val = '0;
    n_mop = rvx_pkg::MOP_NONE;
    n_msz = '0;
    n_addr = '0;
    n_sd = '0;
    n_ldset = 1'b0;
    n_ldclr = 1'b0;
    ok = 1'b1;
    take = 1'b0;
    if (cmd_q != rvx_pkg::CMD_EXEC) begin
      n_npc = pc;
      n_rd = ld_dest;
      if (ld_pend) begin
        n_ldclr = 1'b1;
        n_wr = 1'b1;
        case (ld_kind)
          3'd0: n_val = {{24{ld_q[7]}}, ld_q[7:0]};
          3'd1: n_val = {{16{ld_q[15]}}, ld_q[15:0]};
          3'd4: n_val = {24'd0, ld_q[7:0]};
          3'd5: n_val = {16'd0, ld_q[15:0]};
          default: n_val = ld_q;
        endcase
      end
    end else if (ld_pend) begin
      n_st = rvx_pkg::ST_AWAIT;
      n_npc = pc;
    end else begin
      case (opc_q)
        rvx_pkg::OPC_LUI: begin
          n_wr = 1'b1;
          n_val = imm_q;
        end
        rvx_pkg::OPC_AUIPC: begin
          n_wr = 1'b1;
          n_val = pc + imm_q;
        end
        rvx_pkg::OPC_JAL: begin
          n_wr = 1'b1;
          n_val = pc4;
          n_npc = pc + imm_q;
        end
        rvx_pkg::OPC_JALR: begin
          ok = (f3_q == 3'd0);
          n_wr = 1'b1;
          n_val = pc4;
          n_npc = {sum_ai[31:1], 1'b0};
        end
        rvx_pkg::OPC_BRANCH: begin
          case (f3_q)
            3'd0: take = (op_a == b_cur);
            3'd1: take = (op_a != b_cur);
            3'd4: take = ($signed(op_a) < $signed(b_cur));
            3'd5: take = !($signed(op_a) < $signed(b_cur));
            3'd6: take = (op_a < b_cur);
            3'd7: take = (op_a >= b_cur);
            default: ok = 1'b0;
          endcase
          if (take) n_npc = pc + imm_q;
        end
        rvx_pkg::OPC_LOAD: begin
          ok = !(f3_q == 3'd3 || f3_q > 3'd5);
          n_st = rvx_pkg::ST_AWAIT;
          n_mop = rvx_pkg::MOP_LOAD;
          n_msz = f3_q[1:0];
          n_addr = sum_ai;
          n_ldset = 1'b1;
        end
        rvx_pkg::OPC_STORE: begin
          ok = (f3_q <= 3'd2);
          n_mop = rvx_pkg::MOP_STORE;
          n_msz = f3_q[1:0];
          n_addr = sum_ai;
          n_sd = b_cur;
        end
        rvx_pkg::OPC_OPIMM: begin
          n_wr = 1'b1;
          case (f3_q)
            3'd0: n_val = sum_ai;
            3'd2: n_val = {31'd0, $signed(op_a) < $signed(imm_q)};
            3'd3: n_val = {31'd0, op_a < imm_q};
            3'd4: n_val = op_a ^ imm_q;
            3'd6: n_val = op_a | imm_q;
            3'd7: n_val = op_a & imm_q;
            3'd1: begin
              ok = (f7_q == rvx_pkg::F7_BASE);
              n_val = op_a << shi;
            end
            default: begin
              if (f7_q == rvx_pkg::F7_BASE) n_val = op_a >> shi;
              else if (f7_q == rvx_pkg::F7_ALT) n_val = 32'($signed(op_a) >>> shi);
              else ok = 1'b0;
            end
          endcase
        end
        rvx_pkg::OPC_OP: begin
          n_wr = 1'b1;
          if (f7_q == rvx_pkg::F7_MULDIV) begin
            n_val = '0;
          end else if (f7_q == rvx_pkg::F7_ALT) begin
            if (f3_q == 3'd0) n_val = op_a - b_cur;
            else if (f3_q == 3'd5) n_val = 32'($signed(op_a) >>> shr);
            else ok = 1'b0;
          end else if (f7_q == rvx_pkg::F7_BASE) begin
            case (f3_q)
              3'd0: n_val = op_a + b_cur;
              3'd1: n_val = op_a << shr;
              3'd2: n_val = {31'd0, $signed(op_a) < $signed(b_cur)};
              3'd3: n_val = {31'd0, op_a < b_cur};
              3'd4: n_val = op_a ^ b_cur;
              3'd5: n_val = op_a >> shr;
              3'd6: n_val = op_a | b_cur;
              default: n_val = op_a & b_cur;
            endcase
          end else begin
            ok = 1'b0;
          end
        end
        rvx_pkg::OPC_SYSTEM: begin
          ok = (f3_q == 3'd0) && (imm_q <= 32'd1);
          if (imm_q == 32'd1 || b_cur == exit_num) n_st = rvx_pkg::ST_HALT;
        end
        default: ok = 1'b0;
      endcase
      if (!ok) begin
        n_st = rvx_pkg::ST_ILLEGAL;
        n_npc = pc;
        n_wr = 1'b0;
        n_mop = rvx_pkg::MOP_NONE;
        n_msz = '0;
        n_addr = '0;
        n_sd = '0;
        n_ldset = 1'b0;
      end
    end
  end

  assign sgn_div = !f3_q[0];
  assign dv_sh = {dv_r, dv_q[31]};
  assign dv_ge = dv_sh >= {1'b0, dv_d};
  assign q_fin = neg_q ? -dv_q : dv_q;
  assign r_fin = neg_r ? -dv_r : dv_r;
  assign mul_hi = prod[63:32]
                  - ((f3_q != 3'd3 && op_a[31]) ? op_b : 32'd0)
                  - ((f3_q == 3'd1 && op_b[31]) ? op_a : 32'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_cnt <= '0;
    end else if (cmd.exec) begin
      dv_cnt <= '0;
    end else if (cmd.div_step) begin
      dv_cnt <= dv_cnt + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      cmd_q <= command;
      opc_q <= opcode;
      f3_q <= funct3;
      f7_q <= funct7;
      rd_q <= dest_reg;
      src2_q <= src2_reg;
      imm_q <= immediate;
      ld_q <= load_data;
    end
    if (cmd.rd_src2) op_a <= rok ? rdata : 32'd0;
    if (cmd.exec) begin
      op_b <= b_cur;
      res_st <= n_st;
      res_npc <= n_npc;
      res_wb <= n_wr && (n_rd != 5'd0);
      res_rd <= (n_wr && n_rd != 5'd0) ? n_rd : 5'd0;
      res_val <= (n_wr && n_rd != 5'd0) ? n_val : 32'd0;
      res_mop <= n_mop;
      res_msz <= n_msz;
      res_addr <= n_addr;
      res_sd <= n_sd;
      res_ldset <= n_ldset;
      res_ldclr <= n_ldclr;
      dv_r <= '0;
      dv_q <= (sgn_div && op_a[31]) ? -op_a : op_a;
      dv_d <= (sgn_div && b_cur[31]) ? -b_cur : b_cur;
      neg_q <= sgn_div && (op_a[31] ^ b_cur[31]);
      neg_r <= sgn_div && op_a[31];
      dv_zero <= (b_cur == 32'd0);
    end
    if (cmd.mul) prod <= op_a * op_b;
    if (cmd.mul_fix && res_wb) begin
      res_val <= (f3_q == 3'd0) ? prod[31:0] : mul_hi;
    end
    if (cmd.div_step) begin
      dv_q <= {dv_q[30:0], dv_ge};
      dv_r <= dv_ge ? 32'(dv_sh - {1'b0, dv_d}) : dv_sh[31:0];
    end
    if (cmd.div_fin && res_wb) begin
      if (dv_zero) res_val <= f3_q[1] ? op_a : 32'hFFFF_FFFF;
      else res_val <= f3_q[1] ? r_fin : q_fin;
    end
    if (cmd.commit) begin
      status <= res_st;
      next_pc <= res_npc;
      wb_valid <= res_wb;
      wb_reg <= res_rd;
      wb_value <= res_val;
      mem_op <= res_mop;
      mem_size <= res_msz;
      mem_addr <= res_addr;
      store_data <= res_sd;
    end
  end

endmodule

FILE: src/rv32im_execute_unit.sv
// channel  | handshake            | payload
// in       | in_valid / in_ready  | command .. load_data
// out      | out_valid/ out_ready | status .. store_data
// cfg      | cfg_valid/ cfg_ready | cfg_index, cfg_data
// One request at a time: most instructions pass through source read, execute and commit
// states; multiplies add one 32x32 product, then high-word correction; divides and
// remainders add a radix-2 divider, one quotient bit a cycle.
// Reset clears the register file valid bits, PC and load state.
// A waiting result holds in the output register; the next request is taken
// meanwhile and completes once the output register frees.
module rv32im_execute_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [6:0]  opcode,
  input  logic [2:0]  funct3,
  input  logic [6:0]  funct7,
  input  logic [4:0]  dest_reg,
  input  logic [4:0]  src1_reg,
  input  logic [4:0]  src2_reg,
  input  logic signed [31:0] immediate,
  input  logic [31:0] load_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] next_pc,
  output logic        wb_valid,
  output logic [4:0]  wb_reg,
  output logic [31:0] wb_value,
  output logic [1:0]  mem_op,
  output logic [1:0]  mem_size,
  output logic [31:0] mem_addr,
  output logic [31:0] store_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  rvx_pkg::cmd_t  cmd;
  rvx_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  rvx_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .stat(stat), .cmd(cmd)
  );

  rvx_dpath u_dpath (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .command(command), .opcode(opcode), .funct3(funct3), .funct7(funct7),
    .dest_reg(dest_reg), .src1_reg(src1_reg), .src2_reg(src2_reg),
    .immediate(immediate), .load_data(load_data),
    .status(status), .next_pc(next_pc), .wb_valid(wb_valid), .wb_reg(wb_reg),
    .wb_value(wb_value), .mem_op(mem_op), .mem_size(mem_size),
    .mem_addr(mem_addr), .store_data(store_data)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(next_pc) && $stable(status))
    else $error("waiting result lost");
  a_no_x0_write: assert property (@(posedge clk) disable iff (rst)
    out_valid && wb_valid |-> wb_reg != 5'd0)
    else $error("writeback to x0 reported");
`endif

endmodule

FILE: tb/rv32im_execute_unit_test.sv
`timescale 1ns / 1ps

module rv32im_execute_unit_test;

  localparam logic CMD_LOAD_ANSWER = 1'b1;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] F3_MUL    = 3'd0;
  localparam logic [2:0] F3_MULH   = 3'd1;
  localparam logic [2:0] F3_MULHSU = 3'd2;
  localparam logic [2:0] F3_MULHU  = 3'd3;
  localparam logic [2:0] F3_DIV    = 3'd4;
  localparam logic [2:0] F3_DIVU   = 3'd5;
  localparam logic [2:0] F3_REM    = 3'd6;
  localparam logic [2:0] F3_REMU   = 3'd7;

  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  localparam logic [2:0] F3_LB  = 3'd0;
  localparam logic [2:0] F3_LH  = 3'd1;
  localparam logic [2:0] F3_LW  = 3'd2;
  localparam logic [2:0] F3_LBU = 3'd4;
  localparam logic [2:0] F3_LHU = 3'd5;

  localparam logic [31:0] IMM_ECALL  = 32'd0;
  localparam logic [31:0] IMM_EBREAK = 32'd1;

  typedef struct packed {
    logic        command;
    logic [6:0]  opcode;
    logic [2:0]  funct3;
    logic [6:0]  funct7;
    logic [4:0]  dest_reg;
    logic [4:0]  src1_reg;
    logic [4:0]  src2_reg;
    logic [31:0] immediate;
    logic [31:0] load_data;
  } exec_request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] next_pc;
    logic        wb_valid;
    logic [4:0]  wb_reg;
    logic [31:0] wb_value;
    logic [1:0]  mem_op;
    logic [1:0]  mem_size;
    logic [31:0] mem_addr;
    logic [31:0] store_data;
  } exec_result_t;

  class exec_result_board;
    logic [31:0] regs [32];
    logic [31:0] pc;
    logic        load_pending;
    logic [4:0]  load_dest;
    logic [2:0]  load_kind;
    logic [31:0] start_pc;
    logic [31:0] exit_number;
    exec_result_t pending_results [$];
    int mismatches;

    function void init();
      foreach (regs[i]) regs[i] = '0;
      start_pc = '0;
      exit_number = rvx_pkg::EXIT_CALL_RESET;
      pc = start_pc;
      load_pending = 1'b0;
      load_dest = '0;
      load_kind = '0;
      mismatches = 0;
    endfunction

    function void write_config(logic [1:0] idx, logic [31:0] data);
      if (idx == rvx_pkg::CFG_START_PC) start_pc = data;
      else if (idx == rvx_pkg::CFG_EXIT_CALL) exit_number = data;
    endfunction

    function logic [31:0] rd(logic [4:0] idx);
      return idx == 5'd0 ? 32'd0 : regs[idx];
    endfunction

    function exec_result_t pack(logic [1:0] st, logic [31:0] npc, logic [4:0] dst, logic wb,
                                logic [31:0] val, logic [1:0] mop, logic [1:0] msz,
                                logic [31:0] addr, logic [31:0] sdata);
      exec_result_t r;
      logic w;
      w = wb && dst != 5'd0;
      r.status = st;
      r.next_pc = npc;
      r.wb_valid = w;
      r.wb_reg = w ? dst : 5'd0;
      r.wb_value = w ? val : 32'd0;
      r.mem_op = mop;
      r.mem_size = mop != rvx_pkg::MOP_NONE ? msz : 2'd0;
      r.mem_addr = mop != rvx_pkg::MOP_NONE ? addr : 32'd0;
      r.store_data = mop == rvx_pkg::MOP_STORE ? sdata : 32'd0;
      return r;
    endfunction

    function exec_result_t plain(logic [1:0] st, logic [31:0] npc);
      return pack(st, npc, 5'd0, 1'b0, 32'd0, rvx_pkg::MOP_NONE, 2'd0, 32'd0, 32'd0);
    endfunction

    function logic [31:0] reg_alu(logic [2:0] f3, logic [6:0] f7, logic [31:0] a,
                                  logic [31:0] b, output logic ok);
      logic [63:0] p;
      ok = 1'b1;
      if (f7 == rvx_pkg::F7_MULDIV) begin
        case (f3)
          F3_MUL: return a * b;
          F3_MULH: begin
            p = longint'($signed(a)) * longint'($signed(b));
            return p[63:32];
          end
          F3_MULHSU: begin
            p = longint'($signed(a)) * longint'({32'd0, b});
            return p[63:32];
          end
          F3_MULHU: begin
            p = {32'd0, a} * {32'd0, b};
            return p[63:32];
          end
          F3_DIV: begin
            if (b == 0) return 32'hFFFF_FFFF;
            if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return a;
            return $signed(a) / $signed(b);
          end
          F3_DIVU: return b == 0 ? 32'hFFFF_FFFF : a / b;
          F3_REM: begin
            if (b == 0) return a;
            if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return 32'd0;
            return $signed(a) % $signed(b);
          end
          default: return b == 0 ? a : a % b;
        endcase
      end
      if (f7 == rvx_pkg::F7_ALT) begin
        if (f3 == F3_ADD) return a - b;
        if (f3 == F3_SR) return $signed(a) >>> b[4:0];
        ok = 1'b0;
        return 32'd0;
      end
      if (f7 != rvx_pkg::F7_BASE) begin
        ok = 1'b0;
        return 32'd0;
      end
      case (f3)
        F3_ADD: return a + b;
        F3_SLL: return a << b[4:0];
        F3_SLT: return {31'd0, $signed(a) < $signed(b)};
        F3_SLTU: return {31'd0, a < b};
        F3_XOR: return a ^ b;
        F3_SR: return a >> b[4:0];
        F3_OR: return a | b;
        default: return a & b;
      endcase
    endfunction

    function exec_result_t predict(exec_request_t q);
      logic [31:0] a, b, v, imm, pc4;
      logic ok, taken;
      imm = q.immediate;
      pc4 = pc + 32'd4;
      ok = 1'b1;
      v = '0;
      if (q.command == CMD_LOAD_ANSWER) begin
        if (!load_pending) return plain(rvx_pkg::ST_CONT, pc);
        case (load_kind)
          F3_LB: v = {{24{q.load_data[7]}}, q.load_data[7:0]};
          F3_LH: v = {{16{q.load_data[15]}}, q.load_data[15:0]};
          F3_LBU: v = {24'd0, q.load_data[7:0]};
          F3_LHU: v = {16'd0, q.load_data[15:0]};
          default: v = q.load_data;
        endcase
        if (load_dest != 5'd0) regs[load_dest] = v;
        load_pending = 1'b0;
        return pack(rvx_pkg::ST_CONT, pc, load_dest, 1'b1, v, rvx_pkg::MOP_NONE, 2'd0,
                    32'd0, 32'd0);
      end
      if (load_pending) return plain(rvx_pkg::ST_AWAIT, pc);
      a = rd(q.src1_reg);
      b = rd(q.src2_reg);
      case (q.opcode)
        rvx_pkg::OPC_LUI: v = imm;
        rvx_pkg::OPC_AUIPC: v = pc + imm;
        rvx_pkg::OPC_JAL: begin
          pc = pc + imm;
          if (q.dest_reg != 5'd0) regs[q.dest_reg] = pc4;
          return pack(rvx_pkg::ST_CONT, pc, q.dest_reg, 1'b1, pc4, rvx_pkg::MOP_NONE, 2'd0,
                      32'd0, 32'd0);
        end
        rvx_pkg::OPC_JALR: begin
          if (q.funct3 != F3_ADD) ok = 1'b0;
          else begin
            pc = (a + imm) & ~32'd1;
            if (q.dest_reg != 5'd0) regs[q.dest_reg] = pc4;
            return pack(rvx_pkg::ST_CONT, pc, q.dest_reg, 1'b1, pc4, rvx_pkg::MOP_NONE,
                        2'd0, 32'd0, 32'd0);
          end
        end
        rvx_pkg::OPC_BRANCH: begin
          case (q.funct3)
            F3_BEQ: taken = a == b;
            F3_BNE: taken = a != b;
            F3_BLT: taken = $signed(a) < $signed(b);
            F3_BGE: taken = !($signed(a) < $signed(b));
            F3_BLTU: taken = a < b;
            F3_BGEU: taken = a >= b;
            default: begin
              ok = 1'b0;
              taken = 1'b0;
            end
          endcase
          if (ok) begin
            pc = taken ? pc + imm : pc4;
            return plain(rvx_pkg::ST_CONT, pc);
          end
        end
        rvx_pkg::OPC_LOAD: begin
          if (q.funct3 == 3'd3 || q.funct3 > F3_LHU) ok = 1'b0;
          else begin
            pc = pc4;
            load_pending = 1'b1;
            load_dest = q.dest_reg;
            load_kind = q.funct3;
            return pack(rvx_pkg::ST_AWAIT, pc4, 5'd0, 1'b0, 32'd0, rvx_pkg::MOP_LOAD,
                        q.funct3[1:0], a + imm, 32'd0);
          end
        end
        rvx_pkg::OPC_STORE: begin
          if (q.funct3 > F3_LW) ok = 1'b0;
          else begin
            pc = pc4;
            return pack(rvx_pkg::ST_CONT, pc4, 5'd0, 1'b0, 32'd0, rvx_pkg::MOP_STORE,
                        q.funct3[1:0], a + imm, b);
          end
        end
        rvx_pkg::OPC_OPIMM: begin
          case (q.funct3)
            F3_ADD: v = a + imm;
            F3_SLT: v = {31'd0, $signed(a) < $signed(imm)};
            F3_SLTU: v = {31'd0, a < imm};
            F3_XOR: v = a ^ imm;
            F3_OR: v = a | imm;
            F3_AND: v = a & imm;
            F3_SLL: begin
              if (q.funct7 != rvx_pkg::F7_BASE) ok = 1'b0;
              else v = a << imm[4:0];
            end
            default: begin
              if (q.funct7 == rvx_pkg::F7_BASE) v = a >> imm[4:0];
              else if (q.funct7 == rvx_pkg::F7_ALT) v = $signed(a) >>> imm[4:0];
              else ok = 1'b0;
            end
          endcase
        end
        rvx_pkg::OPC_OP: v = reg_alu(q.funct3, q.funct7, a, b, ok);
        rvx_pkg::OPC_SYSTEM: begin
          if (q.funct3 != F3_ADD || imm > IMM_EBREAK) ok = 1'b0;
          else begin
            pc = pc4;
            if (imm == IMM_EBREAK || rd(rvx_pkg::REG_EXIT_ARG) == exit_number)
              return plain(rvx_pkg::ST_HALT, pc4);
            return plain(rvx_pkg::ST_CONT, pc4);
          end
        end
        default: ok = 1'b0;
      endcase
      if (!ok) return plain(rvx_pkg::ST_ILLEGAL, pc);
      pc = pc4;
      if (q.dest_reg != 5'd0) regs[q.dest_reg] = v;
      return pack(rvx_pkg::ST_CONT, pc4, q.dest_reg, 1'b1, v, rvx_pkg::MOP_NONE, 2'd0,
                  32'd0, 32'd0);
    endfunction

    function void note_request(exec_request_t q);
      pending_results.push_back(predict(q));
    endfunction

    function void report(string what, exec_result_t want, exec_result_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%s: want st=%0d pc=%h wb=%0d x%0d=%h mem=%0d/%0d @%h sd=%h",
                 what, want.status, want.next_pc, want.wb_valid, want.wb_reg, want.wb_value,
                 want.mem_op, want.mem_size, want.mem_addr, want.store_data);
        $display("%s: got  st=%0d pc=%h wb=%0d x%0d=%h mem=%0d/%0d @%h sd=%h",
                 what, got.status, got.next_pc, got.wb_valid, got.wb_reg, got.wb_value,
                 got.mem_op, got.mem_size, got.mem_addr, got.store_data);
      end
    endfunction

    function void check_result(exec_result_t got);
      exec_result_t want;
      if (pending_results.size() == 0) begin
        report("unexpected result", '0, got);
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status || got.next_pc !== want.next_pc ||
          got.wb_valid !== want.wb_valid || got.wb_reg !== want.wb_reg ||
          got.wb_value !== want.wb_value || got.mem_op !== want.mem_op ||
          got.mem_size !== want.mem_size || got.mem_addr !== want.mem_addr ||
          got.store_data !== want.store_data)
        report("result mismatch", want, got);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        command;
  logic [6:0]  opcode;
  logic [2:0]  funct3;
  logic [6:0]  funct7;
  logic [4:0]  dest_reg;
  logic [4:0]  src1_reg;
  logic [4:0]  src2_reg;
  logic signed [31:0] immediate;
  logic [31:0] load_data;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [31:0] next_pc;
  logic        wb_valid;
  logic [4:0]  wb_reg;
  logic [31:0] wb_value;
  logic [1:0]  mem_op;
  logic [1:0]  mem_size;
  logic [31:0] mem_addr;
  logic [31:0] store_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  exec_result_board board;
  bit quiet;
  int stall_left;
  logic [31:0] exit_setting;

  rv32im_execute_unit DUT (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) board.write_config(cfg_index, cfg_data);
      if (in_valid && in_ready)
        board.note_request('{command, opcode, funct3, funct7, dest_reg, src1_reg, src2_reg,
                             immediate, load_data});
      if (out_valid && out_ready)
        board.check_result('{status, next_pc, wb_valid, wb_reg, wb_value, mem_op, mem_size,
                             mem_addr, store_data});
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (!quiet && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 17);
    end
  end

  function automatic logic [4:0] rand_reg();
    return 5'($urandom());
  endfunction

  function automatic logic [2:0] rand_f3();
    return 3'($urandom());
  endfunction

  function automatic logic [6:0] rand_opc();
    return 7'($urandom());
  endfunction

  task automatic send(logic cmd, logic [6:0] opc, logic [2:0] f3, logic [6:0] f7,
                      logic [4:0] rd, logic [4:0] rs1, logic [4:0] rs2, logic [31:0] imm,
                      logic [31:0] data);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    opcode <= opc;
    funct3 <= f3;
    funct7 <= f7;
    dest_reg <= rd;
    src1_reg <= rs1;
    src2_reg <= rs2;
    immediate <= imm;
    load_data <= data;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic run(logic [6:0] opc, logic [2:0] f3, logic [6:0] f7, logic [4:0] rd,
                     logic [4:0] rs1, logic [4:0] rs2, logic [31:0] imm);
    send(rvx_pkg::CMD_EXEC, opc, f3, f7, rd, rs1, rs2, imm, $urandom());
  endtask

  task automatic answer(logic [31:0] data);
    send(CMD_LOAD_ANSWER, rand_opc(), rand_f3(), rand_opc(), rand_reg(), rand_reg(),
         rand_reg(), $urandom(), data);
  endtask

  // hold until every request has its result, then let the divider settle
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_imm();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return {$urandom_range(0, 1) ? 20'hFFFFF : 20'h0, 12'($urandom())};
      2: return 32'($urandom_range(0, 40)) - 32'd8;
      default: return {20'($urandom()), 12'd0};
    endcase
  endfunction

  function automatic logic [6:0] rand_f7();
    case ($urandom_range(0, 9))
      0: return rand_opc();
      1, 2, 3: return rvx_pkg::F7_MULDIV;
      4, 5: return rvx_pkg::F7_ALT;
      default: return rvx_pkg::F7_BASE;
    endcase
  endfunction

  task automatic random_item();
    int k;
    int follow;
    k = $urandom_range(0, 99);
    if (k < 28) run(rvx_pkg::OPC_OP, rand_f3(), rand_f7(), rand_reg(), rand_reg(), rand_reg(),
                    $urandom());
    else if (k < 44) run(rvx_pkg::OPC_OPIMM, rand_f3(), $urandom_range(0, 5) == 0 ? rand_f7() :
                         ($urandom_range(0, 1) ? rvx_pkg::F7_ALT : rvx_pkg::F7_BASE),
                         rand_reg(), rand_reg(), rand_reg(), rand_imm());
    else if (k < 50) run($urandom_range(0, 1) ? rvx_pkg::OPC_LUI : rvx_pkg::OPC_AUIPC,
                         rand_f3(), rand_opc(), rand_reg(), rand_reg(), rand_reg(),
                         rand_imm());
    else if (k < 57) run(rvx_pkg::OPC_BRANCH, rand_f3(), rand_opc(), rand_reg(), rand_reg(),
                         rand_reg(), rand_imm());
    else if (k < 62) run($urandom_range(0, 1) ? rvx_pkg::OPC_JAL : rvx_pkg::OPC_JALR,
                         $urandom_range(0, 4) == 0 ? rand_f3() : F3_ADD, rand_opc(),
                         rand_reg(), rand_reg(), rand_reg(), rand_imm());
    else if (k < 75) begin
      run(rvx_pkg::OPC_LOAD, $urandom_range(0, 6) == 0 ? rand_f3() : 3'($urandom_range(0, 5)),
          rand_opc(), rand_reg(), rand_reg(), rand_reg(), rand_imm());
      follow = $urandom_range(0, 9);
      if (follow < 2) run(rvx_pkg::OPC_OPIMM, F3_ADD, rvx_pkg::F7_BASE, rand_reg(), rand_reg(),
                          5'd0, rand_imm());
      if (follow < 9) answer($urandom());
    end else if (k < 83) run(rvx_pkg::OPC_STORE, 3'($urandom_range(0, 3)), rand_opc(),
                             rand_reg(), rand_reg(), rand_reg(), rand_imm());
    else if (k < 90) begin
      if ($urandom_range(0, 1))
        run(rvx_pkg::OPC_OPIMM, F3_ADD, rvx_pkg::F7_BASE, rvx_pkg::REG_EXIT_ARG, 5'd0, 5'd0,
            exit_setting);
      run(rvx_pkg::OPC_SYSTEM, $urandom_range(0, 3) == 0 ? rand_f3() : F3_ADD, rand_opc(),
          rand_reg(), rand_reg(), rand_reg(),
          $urandom_range(0, 4) == 0 ? rand_imm() : 32'($urandom_range(0, 1)));
    end else if (k < 95) run(rand_opc(), rand_f3(), rand_opc(), rand_reg(), rand_reg(),
                             rand_reg(), $urandom());
    else answer($urandom());
  endtask

  initial begin
    board = new();
    board.init();
    quiet = 1'b1;
    stall_left = 0;
    exit_setting = rvx_pkg::EXIT_CALL_RESET;
    rst <= 1'b1;
    in_valid <= 1'b0;
    out_ready <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    command <= rvx_pkg::CMD_EXEC;
    opcode <= '0;
    funct3 <= '0;
    funct7 <= '0;
    dest_reg <= '0;
    src1_reg <= '0;
    src2_reg <= '0;
    immediate <= '0;
    load_data <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    quiet = 1'b0;

    run(rvx_pkg::OPC_LUI, F3_ADD, rvx_pkg::F7_BASE, 5'd1, 5'd0, 5'd0, 32'hFFFF_F000);
    run(rvx_pkg::OPC_OPIMM, F3_ADD, rvx_pkg::F7_BASE, 5'd2, 5'd0, 5'd0, 32'hFFFF_FFFF);
    run(rvx_pkg::OPC_LUI, F3_ADD, rvx_pkg::F7_BASE, 5'd4, 5'd0, 5'd0, 32'h8000_0000);
    run(rvx_pkg::OPC_OPIMM, F3_ADD, rvx_pkg::F7_BASE, 5'd3, 5'd0, 5'd0, 32'h7FFF_FFFF);
    run(rvx_pkg::OPC_OP, F3_ADD, rvx_pkg::F7_BASE, 5'd0, 5'd2, 5'd3, 32'd0);
    run(rvx_pkg::OPC_OP, F3_MULH, rvx_pkg::F7_MULDIV, 5'd5, 5'd4, 5'd2, 32'd0);
    run(rvx_pkg::OPC_OP, F3_MULHSU, rvx_pkg::F7_MULDIV, 5'd6, 5'd2, 5'd2, 32'd0);
    run(rvx_pkg::OPC_OP, F3_MULHU, rvx_pkg::F7_MULDIV, 5'd7, 5'd2, 5'd3, 32'd0);
    run(rvx_pkg::OPC_OP, F3_DIV, rvx_pkg::F7_MULDIV, 5'd8, 5'd4, 5'd2, 32'd0);
    run(rvx_pkg::OPC_OP, F3_REM, rvx_pkg::F7_MULDIV, 5'd9, 5'd4, 5'd2, 32'd0);
    run(rvx_pkg::OPC_OP, F3_DIVU, rvx_pkg::F7_MULDIV, 5'd10, 5'd3, 5'd0, 32'd0);
    run(rvx_pkg::OPC_OP, F3_REMU, rvx_pkg::F7_MULDIV, 5'd11, 5'd3, 5'd0, 32'd0);
    run(rvx_pkg::OPC_OPIMM, F3_SR, rvx_pkg::F7_ALT, 5'd12, 5'd4, 5'd0, 32'd31);
    run(rvx_pkg::OPC_OPIMM, F3_SR, 7'h7F, 5'd12, 5'd4, 5'd0, 32'd3);
    run(rvx_pkg::OPC_JALR, F3_ADD, rvx_pkg::F7_BASE, 5'd13, 5'd13, 5'd0, 32'd7);
    run(rvx_pkg::OPC_BRANCH, F3_BLT, rvx_pkg::F7_BASE, 5'd0, 5'd4, 5'd3, 32'hFFFF_FFF0);
    run(rvx_pkg::OPC_LOAD, F3_LB, rvx_pkg::F7_BASE, 5'd14, 5'd2, 5'd0, 32'd1);
    run(rvx_pkg::OPC_OP, F3_ADD, rvx_pkg::F7_BASE, 5'd15, 5'd2, 5'd2, 32'd0);
    answer(32'h1234_5680);
    answer(32'hFFFF_FFFF);
    run(rvx_pkg::OPC_STORE, F3_LW, rvx_pkg::F7_BASE, 5'd0, 5'd4, 5'd2, 32'h8000_0000);
    run(rvx_pkg::OPC_OPIMM, F3_ADD, rvx_pkg::F7_BASE, rvx_pkg::REG_EXIT_ARG, 5'd0, 5'd0,
        rvx_pkg::EXIT_CALL_RESET);
    run(rvx_pkg::OPC_SYSTEM, F3_ADD, rvx_pkg::F7_BASE, 5'd0, 5'd0, 5'd0, IMM_ECALL);
    run(rvx_pkg::OPC_SYSTEM, F3_ADD, rvx_pkg::F7_BASE, 5'd0, 5'd0, 5'd0, IMM_EBREAK);
    run(rvx_pkg::OPC_SYSTEM, F3_ADD, rvx_pkg::F7_BASE, 5'd0, 5'd0, 5'd0, 32'd2);
    run(7'h7F, F3_AND, 7'h7F, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF);

    for (int phase = 0; phase < 4; phase++) begin
      drain();
      case (phase)
        0: exit_setting = 32'd0;
        1: exit_setting = 32'hFFFF_FFFF;
        2: exit_setting = $urandom();
        default: exit_setting = rvx_pkg::EXIT_CALL_RESET;
      endcase
      write_reg(rvx_pkg::CFG_EXIT_CALL, exit_setting);
      write_reg(rvx_pkg::CFG_START_PC, phase == 1 ? 32'hFFFF_FFFF : 32'($urandom()));
      quiet = phase == 3;
      repeat (155) random_item();
    end

    in_valid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (board.mismatches == 0 && board.pending_results.size() == 0) begin
      $display("** rv32im_execute_unit: PASSED **");
    end else begin
      $display("** rv32im_execute_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** rv32im_execute_unit: FAILED **");
    $finish;
  end

endmodule
